>>> rtl/srxl_fpe_pkg.sv
// ----------------------------------------------------------------------------
// SRXL frame pulse encoder package
// Shared constants and the queue entry type that links front and back.
// ----------------------------------------------------------------------------
package srxl_fpe_pkg;

	localparam int NUM_CHANNELS = 12;
	localparam int CNT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam int CHAN_W  = 16;
	localparam int VALUE_W = 12;
	localparam int TICKS_W = 16;
	localparam int BT_W    = 5;

	localparam logic [BT_W-1:0] BIT_TICKS_RESET = 5'd18;

	typedef struct packed {
		logic [VALUE_W-1:0] value;  // offset and clamped channel value
		logic               first;  // first channel of a frame
		logic               last;   // last channel of a frame
	} item_t;

endpackage

>>> rtl/srxl_fpe_front.sv
// ----------------------------------------------------------------------------
// SRXL frame pulse encoder front
// Accepts channel values, clamps them and marks frame start and end.
// ----------------------------------------------------------------------------
module srxl_fpe_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [srxl_fpe_pkg::CHAN_W-1:0] channel_value,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              q_full,
	output logic                              q_push,
	output srxl_fpe_pkg::item_t               q_item
);
	import srxl_fpe_pkg::*;

	logic [CNT_W-1:0] chan_cnt_q;
	logic             is_last;
	logic             too_low;
	logic             too_high;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	assign is_last  = (chan_cnt_q == CNT_W'(NUM_CHANNELS - 1));
	// value + 2048 below zero or above 4095
	assign too_low  = (channel_value < -16'sd2048);
	assign too_high = (channel_value > 16'sd2047);

	always_comb begin
		q_item.first = (chan_cnt_q == '0);
		q_item.last  = is_last;
		if (too_low) begin
			q_item.value = '0;
		end else if (too_high) begin
			q_item.value = '1;
		end else begin
			q_item.value = {~channel_value[VALUE_W-1], channel_value[VALUE_W-2:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= '0;
		end else if (q_push) begin
			chan_cnt_q <= is_last ? '0 : chan_cnt_q + CNT_W'(1);
		end
	end

endmodule

>>> rtl/srxl_fpe_queue.sv
// ----------------------------------------------------------------------------
// SRXL frame pulse encoder queue
// Two-entry queue between the front and the pulse sequencer.
// ----------------------------------------------------------------------------
module srxl_fpe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  srxl_fpe_pkg::item_t push_item,
	output logic                full,
	input  logic                pop,
	output logic                pop_valid,
	output srxl_fpe_pkg::item_t pop_item
);
	import srxl_fpe_pkg::*;

	item_t       entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/srxl_fpe_back.sv
// ----------------------------------------------------------------------------
// SRXL frame pulse encoder back
// Sequences the bytes of each item, keeps the CRC and emits one run per beat.
// ----------------------------------------------------------------------------
module srxl_fpe_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [srxl_fpe_pkg::BT_W-1:0]        bit_ticks,
	input  logic                                 q_valid,
	input  srxl_fpe_pkg::item_t                  q_item,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [srxl_fpe_pkg::TICKS_W-1:0]     pulse_ticks,
	output logic                                 last_of_run,
	output logic                                 frame_done
);
	import srxl_fpe_pkg::*;

	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [7:0]  START_BYTE  = 8'hA1;
	localparam logic [TICKS_W-1:0] FLUSH_TICKS = 16'd60000;
	localparam int FRAME_BITS = 10;

	typedef enum logic [2:0] {
		K_START, K_HI, K_LO, K_CRC_HI, K_CRC_LO, K_FLUSH
	} kind_t;

	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	logic                busy_q;
	kind_t               kind_q;
	logic [9:0]          sh_q;
	logic [3:0]          rem_q;
	logic [15:0]         crc_q;
	logic                parity_q;
	logic [VALUE_W-1:0]  value_q;
	logic                last_q;
	logic                out_valid_q;
	logic [TICKS_W-1:0]  pulse_ticks_q;
	logic                last_of_run_q;
	logic                frame_done_q;

	logic                adv;
	logic                emit;
	logic                is_flush;
	logic [9:0]          diff;
	logic [3:0]          run_k;
	logic                found;
	logic                closing;
	logic [8:0]          run_len;
	logic signed [10:0]  adj;
	logic signed [10:0]  run_sum;
	logic [TICKS_W-1:0]  run_ticks;
	logic                replace;
	logic                item_end;
	logic                to_flush;
	logic                next_byte;
	logic                load;
	logic [7:0]          byte_in;
	logic [15:0]         crc_base;
	logic                crc_upd;
	kind_t               kind_in;
	logic [15:0]         crc_new;

	assign adv      = !out_valid_q || out_ready;
	assign emit     = busy_q && adv;
	assign is_flush = (kind_q == K_FLUSH);

	// length of the run of equal bits starting at the line position
	always_comb begin
		diff  = sh_q ^ {FRAME_BITS{sh_q[0]}};
		run_k = rem_q;
		found = 1'b0;
		for (int i = 1; i < FRAME_BITS; i++) begin
			if (!found && (4'(i) < rem_q) && diff[i]) begin
				run_k = 4'(i);
				found = 1'b1;
			end
		end
	end

	assign closing = (run_k == rem_q);
	assign run_len = {5'b0, run_k} * {4'b0, bit_ticks};

	always_comb begin
		case ({parity_q, closing})
			2'b11:   adj = 11'sd4;
			2'b10:   adj = 11'sd1;
			2'b01:   adj = 11'sd0;
			default: adj = -11'sd3;
		endcase
	end

	assign run_sum   = $signed({2'b00, run_len}) + adj;
	assign run_ticks = run_sum[10] ? '0 : {6'b0, run_sum[9:0]};

	// parity after the last CRC run decides: replace it or append the flush
	assign replace  = (kind_q == K_CRC_LO) && closing && parity_q;
	assign to_flush = emit && !is_flush && closing && (kind_q == K_CRC_LO) && !parity_q;
	assign item_end = emit && (is_flush || replace
	                  || (!is_flush && closing && (kind_q == K_LO) && !last_q));
	assign next_byte = emit && !is_flush && closing && !item_end && !to_flush;
	assign load      = q_valid && (!busy_q || item_end);
	assign q_pop     = load;

	always_comb begin
		byte_in  = START_BYTE;
		crc_base = crc_q;
		crc_upd  = 1'b0;
		kind_in  = kind_q;
		if (load) begin
			crc_upd = 1'b1;
			if (q_item.first) begin
				byte_in  = START_BYTE;
				crc_base = '0;
				kind_in  = K_START;
			end else begin
				byte_in = {4'b0, q_item.value[VALUE_W-1:8]};
				kind_in = K_HI;
			end
		end else begin
			case (kind_q)
				K_START: begin
					byte_in = {4'b0, value_q[VALUE_W-1:8]};
					kind_in = K_HI;
					crc_upd = 1'b1;
				end
				K_HI: begin
					byte_in = value_q[7:0];
					kind_in = K_LO;
					crc_upd = 1'b1;
				end
				K_LO: begin
					byte_in = crc_q[15:8];
					kind_in = K_CRC_HI;
				end
				K_CRC_HI: begin
					byte_in = crc_q[7:0];
					kind_in = K_CRC_LO;
				end
				default: begin
					byte_in = crc_q[7:0];
					kind_in = kind_q;
				end
			endcase
		end
	end

	assign crc_new = crc_add(crc_base, byte_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			kind_q        <= K_START;
			sh_q          <= '0;
			rem_q         <= '0;
			crc_q         <= '0;
			parity_q      <= 1'b0;
			value_q       <= '0;
			last_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			pulse_ticks_q <= '0;
			last_of_run_q <= 1'b0;
			frame_done_q  <= 1'b0;
		end else begin
			if (load) begin
				busy_q  <= 1'b1;
				value_q <= q_item.value;
				last_q  <= q_item.last;
			end else if (item_end) begin
				busy_q <= 1'b0;
			end

			if (load || next_byte) begin
				kind_q <= kind_in;
				sh_q   <= {1'b1, byte_in, 1'b0};
				rem_q  <= 4'(FRAME_BITS);
				if (crc_upd) begin
					crc_q <= crc_new;
				end
			end else if (to_flush) begin
				kind_q <= K_FLUSH;
			end else if (emit && !is_flush) begin
				sh_q  <= sh_q >> run_k;
				rem_q <= rem_q - run_k;
			end

			if (load && q_item.first) begin
				parity_q <= 1'b0;
			end else if (emit && !is_flush) begin
				parity_q <= ~parity_q;
			end

			// hold the result while the receiver stalls
			if (adv) begin
				out_valid_q   <= emit;
				pulse_ticks_q <= (is_flush || replace) ? FLUSH_TICKS : run_ticks;
				last_of_run_q <= item_end;
				frame_done_q  <= item_end && (is_flush || replace);
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pulse_ticks = pulse_ticks_q;
	assign last_of_run = last_of_run_q;
	assign frame_done  = frame_done_q;

endmodule

>>> rtl/srxl_frame_pulse_encoder.sv
// ----------------------------------------------------------------------------
// SRXL frame pulse encoder
// Turns servo channel values into the serial line run durations of a frame.
// ----------------------------------------------------------------------------
// Input channel: one signed channel value per beat (in_valid / in_ready),
// twelve beats per frame. Output channel: one run duration per beat
// (out_valid / out_ready) with last_of_run on the final run of each input
// beat and frame_done on the final run of a frame.
// Each channel gives 2 bytes, the first channel also the start byte and the
// last channel also the two CRC bytes; each byte yields 2 to 10 runs, plus
// one flush run per frame when the run count is odd.
// The first run of an accepted channel passes through the queue, the byte shift register and the output register.
// Throughput: one run per cycle while out_ready holds and the queue has an item,
// sustained across items; the run sequencer sets this.
// A two-entry queue lets the input side keep accepting, until it fills, while the output
// side is stalled; a stalled output holds its run and the sequencer waits.
// The user must write bit_ticks (cfg_wr_en / cfg_wr_data) only while idle; the block does not enforce this.
// Reset clears the channel count, CRC, queue and output; bit_ticks goes to 18.
// ----------------------------------------------------------------------------
module srxl_frame_pulse_encoder (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_wr_en,
	input  logic [srxl_fpe_pkg::BT_W-1:0]             cfg_wr_data,
	input  logic signed [srxl_fpe_pkg::CHAN_W-1:0]    channel_value,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	output logic [srxl_fpe_pkg::TICKS_W-1:0]          pulse_ticks,
	output logic                                      last_of_run,
	output logic                                      frame_done,
	output logic                                      out_valid,
	input  logic                                      out_ready
);
	import srxl_fpe_pkg::*;

	logic [BT_W-1:0] bit_ticks_q;
	logic            q_full;
	logic            q_push;
	item_t           push_item;
	logic            q_pop;
	logic            q_valid;
	item_t           pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q <= BIT_TICKS_RESET;
		end else if (cfg_wr_en) begin
			bit_ticks_q <= cfg_wr_data;
		end
	end

	srxl_fpe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.channel_value (channel_value),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	srxl_fpe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (pop_item)
	);

	srxl_fpe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.bit_ticks   (bit_ticks_q),
		.q_valid     (q_valid),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pulse_ticks (pulse_ticks),
		.last_of_run (last_of_run),
		.frame_done  (frame_done)
	);

endmodule
